// ===== src/swlc_pkg.sv =====
`timescale 1ns / 1ps
package swlc_pkg;

  localparam int ENTRIES  = 16;
  localparam int TAG_W    = 64;
  localparam int SIZE_W   = 32;
  localparam int HANDLE_W = 32;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_PROBE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_MISS   = 2'd1,
    STAT_REJECT = 2'd2,
    STAT_EVICT  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_EXEC,
    S_EVICT,
    S_INSERT,
    S_DRAIN,
    S_FINAL
  } state_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [TAG_W-1:0]    key_tag;
    logic [SIZE_W-1:0]   item_size;
    logic [HANDLE_W-1:0] item_handle;
    logic                too_large;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [SIZE_W-1:0]   out_size;
    logic [HANDLE_W-1:0] out_handle;
    logic [TAG_W-1:0]    evicted_tag;
    logic [SIZE_W-1:0]   occupancy;
    logic                last;
  } res_t;

endpackage

// ===== src/swlc_front.sv =====
`timescale 1ns / 1ps
module swlc_front import swlc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SIZE_W-1:0]   cfg_data_i,
  input  logic                push_i,
  output logic                full_o,
  input  logic [1:0]          cmd_i,
  input  logic [TAG_W-1:0]    key_tag_i,
  input  logic [SIZE_W-1:0]   item_size_i,
  input  logic [HANDLE_W-1:0] item_handle_i,
  output logic [SIZE_W-1:0]   capacity_o,
  output logic                req_valid_o,
  output req_t                req_o,
  input  logic                req_pop_i
);

  logic [SIZE_W-1:0] capacity_q;
  req_t              mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              do_push, do_pop;
  req_t              req_in;

  assign full_o      = (count_q == 2'd2);
  assign req_valid_o = (count_q != 2'd0);
  assign req_o       = mem_q[rd_ptr_q];
  assign capacity_o  = capacity_q;
  assign do_push     = push_i && !full_o;
  assign do_pop      = req_pop_i && req_valid_o;

  always_comb begin
    req_in.cmd         = cmd_e'(cmd_i);
    req_in.key_tag     = key_tag_i;
    req_in.item_size   = item_size_i;
    req_in.item_handle = item_handle_i;
    req_in.too_large   = (item_size_i > capacity_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= '0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      count_q    <= 2'd0;
    end else begin
      if (cfg_we_i) capacity_q <= cfg_data_i;
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= req_in;
  end

endmodule

// ===== src/swlc_outq.sv =====
`timescale 1ns / 1ps
module swlc_outq import swlc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign res_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= res_i;
  end

endmodule

// ===== src/swlc_back.sv =====
`timescale 1ns / 1ps
module swlc_back import swlc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SIZE_W-1:0] capacity_i,
  input  logic              req_valid_i,
  input  req_t              req_i,
  output logic              req_pop_o,
  output logic              res_push_o,
  output res_t              res_o,
  input  logic              res_full_i
);

  state_e state_q, state_d;
  req_t   req_q;

  logic [TAG_W-1:0]    tag_q    [ENTRIES];
  logic [SIZE_W-1:0]   size_q   [ENTRIES];
  logic [HANDLE_W-1:0] handle_q [ENTRIES];
  logic [IDX_W-1:0]    rank_q   [ENTRIES];
  logic [ENTRIES-1:0]  valid_q;
  logic [CNT_W-1:0]    count_q;
  logic [SIZE_W-1:0]   total_q, limit_q;

  logic                hit_q;
  logic [IDX_W-1:0]    hit_idx_q;

  logic [TAG_W-1:0]    ev_tag_q    [ENTRIES];
  logic [SIZE_W-1:0]   ev_size_q   [ENTRIES];
  logic [HANDLE_W-1:0] ev_handle_q [ENTRIES];
  logic [CNT_W-1:0]    ev_cnt_q, rd_ptr_q;

  status_e             fin_status_q;
  logic [SIZE_W-1:0]   fin_size_q;
  logic [HANDLE_W-1:0] fin_handle_q;

  logic                hit;
  logic [IDX_W-1:0]    hit_idx, lru_idx, free_idx, lru_rank;
  logic                evict_go, drain_more;
  logic                do_free, do_touch, do_insert, ev_push;
  logic [IDX_W-1:0]    sel_idx;

  // tag match, LRU and free-slot search
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    lru_idx  = '0;
    free_idx = '0;
    lru_rank = IDX_W'(count_q - 1'b1);
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && tag_q[i] == req_q.key_tag) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (valid_q[i] && rank_q[i] == lru_rank) lru_idx = IDX_W'(i);
      if (!valid_q[i]) free_idx = IDX_W'(i);
    end
  end

  assign evict_go   = (count_q == CNT_W'(ENTRIES)) ||
                      ((total_q > limit_q) && (count_q != '0));
  assign drain_more = (rd_ptr_q != ev_cnt_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (req_valid_i) state_d = S_LOOKUP;
      S_LOOKUP: state_d = S_EXEC;
      S_EXEC: begin
        if (req_q.cmd == CMD_PUT && !req_q.too_large) state_d = S_EVICT;
        else state_d = S_FINAL;
      end
      S_EVICT:  if (!evict_go) state_d = S_INSERT;
      S_INSERT: state_d = S_DRAIN;
      S_DRAIN:  if (!drain_more) state_d = S_FINAL;
      S_FINAL:  if (!res_full_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_pop_o  = 1'b0;
    res_push_o = 1'b0;
    do_free    = 1'b0;
    do_touch   = 1'b0;
    do_insert  = 1'b0;
    ev_push    = 1'b0;
    sel_idx    = hit_idx_q;
    res_o      = '{status: STAT_EVICT, out_size: ev_size_q[rd_ptr_q[IDX_W-1:0]],
                   out_handle: ev_handle_q[rd_ptr_q[IDX_W-1:0]],
                   evicted_tag: ev_tag_q[rd_ptr_q[IDX_W-1:0]],
                   occupancy: total_q, last: 1'b0};
    unique case (state_q)
      S_IDLE: req_pop_o = req_valid_i;
      S_EXEC: begin
        if (hit_q) begin
          if ((req_q.cmd == CMD_PUT && !req_q.too_large) || req_q.cmd == CMD_REMOVE) begin
            do_free = 1'b1;
          end
          if (req_q.cmd == CMD_GET) do_touch = 1'b1;
        end
      end
      S_EVICT: begin
        sel_idx = lru_idx;
        do_free = evict_go;
        ev_push = evict_go;
      end
      S_INSERT: do_insert = 1'b1;
      S_DRAIN:  res_push_o = drain_more && !res_full_i;
      S_FINAL: begin
        res_push_o = !res_full_i;
        res_o      = '{status: fin_status_q, out_size: fin_size_q,
                       out_handle: fin_handle_q, evicted_tag: '0,
                       occupancy: total_q, last: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      count_q  <= '0;
      total_q  <= '0;
      ev_cnt_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_LOOKUP) ev_cnt_q <= '0;
      if (ev_push) ev_cnt_q <= ev_cnt_q + 1'b1;
      if (state_q == S_INSERT) rd_ptr_q <= '0;
      if (state_q == S_DRAIN && res_push_o) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_free) begin
        valid_q[sel_idx] <= 1'b0;
        count_q          <= count_q - 1'b1;
        total_q          <= total_q - size_q[sel_idx];
      end
      if (do_insert) begin
        valid_q[free_idx] <= 1'b1;
        count_q           <= count_q + 1'b1;
        total_q           <= total_q + req_q.item_size;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) req_q <= req_i;
    if (state_q == S_LOOKUP) begin
      hit_q     <= hit;
      hit_idx_q <= hit_idx;
    end
    if (state_q == S_EXEC) begin
      limit_q    <= capacity_i - req_q.item_size;
      fin_size_q <= '0;
      fin_handle_q <= '0;
      if (req_q.cmd == CMD_PUT) begin
        fin_status_q <= req_q.too_large ? STAT_REJECT : STAT_DONE;
      end else if (!hit_q) begin
        fin_status_q <= STAT_MISS;
      end else begin
        fin_status_q <= STAT_DONE;
        if (req_q.cmd != CMD_REMOVE) begin
          fin_size_q   <= size_q[hit_idx_q];
          fin_handle_q <= handle_q[hit_idx_q];
        end
      end
    end
    if (ev_push) begin
      ev_tag_q[ev_cnt_q[IDX_W-1:0]]    <= tag_q[sel_idx];
      ev_size_q[ev_cnt_q[IDX_W-1:0]]   <= size_q[sel_idx];
      ev_handle_q[ev_cnt_q[IDX_W-1:0]] <= handle_q[sel_idx];
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_free && valid_q[i] && rank_q[i] > rank_q[sel_idx]) rank_q[i] <= rank_q[i] - 1'b1;
      if (do_touch && valid_q[i] && rank_q[i] < rank_q[sel_idx]) rank_q[i] <= rank_q[i] + 1'b1;
      if (do_insert && valid_q[i]) rank_q[i] <= rank_q[i] + 1'b1;
    end
    if (do_touch) rank_q[sel_idx] <= '0;
    if (do_insert) begin
      rank_q[free_idx]   <= '0;
      tag_q[free_idx]    <= req_q.key_tag;
      size_q[free_idx]   <= req_q.item_size;
      handle_q[free_idx] <= req_q.item_handle;
    end
  end

endmodule

// ===== src/size_weighted_lru_cache.sv =====
`timescale 1ns / 1ps
// Size-weighted LRU table of 16 entries (tag, size, handle) ordered by recency.
// Commands are queued on push/full, results come out on empty/pop. During a
// put that is not rejected, the engine evicts one entry per cycle as needed
// and then streams the buffered eviction notices, each carrying the final
// occupancy. A full result queue stalls the engine for as long as it stays full.
module size_weighted_lru_cache import swlc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SIZE_W-1:0]   cfg_data_i,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          cmd_i,
  input  logic [TAG_W-1:0]    key_tag_i,
  input  logic [SIZE_W-1:0]   item_size_i,
  input  logic [HANDLE_W-1:0] item_handle_i,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          status_o,
  output logic [SIZE_W-1:0]   out_size_o,
  output logic [HANDLE_W-1:0] out_handle_o,
  output logic [TAG_W-1:0]    evicted_tag_o,
  output logic [SIZE_W-1:0]   occupancy_o,
  output logic                last_o
);

  logic [SIZE_W-1:0] capacity;
  logic              req_valid, req_pop, res_push, res_full;
  req_t              req;
  res_t              res_in, res_out;

  swlc_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .push_i      (push),
    .full_o      (full),
    .cmd_i, .key_tag_i, .item_size_i, .item_handle_i,
    .capacity_o  (capacity),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_pop_i   (req_pop)
  );

  swlc_back u_back (
    .clk_i, .rst_ni,
    .capacity_i  (capacity),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  swlc_outq u_outq (
    .clk_i, .rst_ni,
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res_out)
  );

  assign status_o      = res_out.status;
  assign out_size_o    = res_out.out_size;
  assign out_handle_o  = res_out.out_handle;
  assign evicted_tag_o = res_out.evicted_tag;
  assign occupancy_o   = res_out.occupancy;
  assign last_o        = res_out.last;

endmodule

// ===== src/swlc_checker.sv =====
`timescale 1ns / 1ps
module swlc_checker import swlc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic [1:0]        status_o,
  input logic [SIZE_W-1:0] out_size_o,
  input logic [TAG_W-1:0]  evicted_tag_o,
  input logic [SIZE_W-1:0] occupancy_o,
  input logic              last_o
);

  // eviction notices never close an item
  a_evict_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == STAT_EVICT) |-> !last_o)
    else $error("eviction notice marked last");

  a_miss_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o == STAT_MISS || status_o == STAT_REJECT)) |->
      (last_o && out_size_o == '0 && evicted_tag_o == '0))
    else $error("miss or reject result malformed");

  // all results of one item report the same occupancy
  a_occ_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> (empty || occupancy_o == $past(occupancy_o)))
    else $error("occupancy changed within one item");

endmodule

bind size_weighted_lru_cache swlc_checker u_swlc_checker (
  .clk_i, .rst_ni, .empty, .pop, .status_o, .out_size_o,
  .evicted_tag_o, .occupancy_o, .last_o
);
